// ----- sv/rlcm_pkg.sv -----
// ----------------------------------------------------------------------------
// rlcm_pkg
// Shared types and constants of the linear resampler with channel mapping.
// ----------------------------------------------------------------------------
package rlcm_pkg;

    localparam int NUM_CH     = 8;   // channel fields on the stream ports
    localparam int CH_CFG_W   = 4;   // channel count register width
    localparam int STEP_W     = 21;  // step ratio register width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] REG_IN_CH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;

    // what the back end does with a queued frame
    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,  // first frame of a stream, store only
        KIND_RUN   = 2'd1,  // interpolate from the held frame
        KIND_FLUSH = 2'd2   // final frame, drain and clear
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  two_frames;  // flush with a held frame in front of it
    } t_cmd_ctl;

    typedef enum logic [1:0] {
        MODE_EQ     = 2'd0,  // per-channel interpolation
        MODE_MEAN   = 2'd1,  // mean of all input channels
        MODE_REPEAT = 2'd2   // input channel zero on every output
    } t_mode;

    typedef struct packed {
        t_mode                mode;
        logic [CH_CFG_W-1:0]  in_ch;   // clamped to 1..MAX_CHANNELS
        logic [CH_CFG_W-1:0]  out_ch;  // clamped to 1..MAX_CHANNELS
    } t_chmap;

endpackage

// ----- sv/rlcm_front.sv -----
// ----------------------------------------------------------------------------
// rlcm_front
// Input side: accepts frames, tags each one as load, run or flush.
// ----------------------------------------------------------------------------
module rlcm_front #(
    parameter int MAXC = 8,
    parameter int SB   = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rlcm_pkg::NUM_CH*SB-1:0] i_data,
    input  logic                          i_last,
    input  logic                          i_q_full,
    output logic                          o_push,
    output rlcm_pkg::t_cmd_ctl            o_ctl,
    output logic [MAXC*SB-1:0]            o_samples
);

    logic r_have_held;
    logic n_have_held;

    assign o_ready   = !i_q_full;
    assign o_push    = i_valid && !i_q_full;
    assign o_samples = i_data[MAXC*SB-1:0];

    always_comb begin
        o_ctl.two_frames = r_have_held;
        if (i_last) begin
            o_ctl.kind = rlcm_pkg::KIND_FLUSH;
        end else if (r_have_held) begin
            o_ctl.kind = rlcm_pkg::KIND_RUN;
        end else begin
            o_ctl.kind = rlcm_pkg::KIND_LOAD;
        end
        n_have_held = r_have_held;
        if (o_push) begin
            n_have_held = !i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_held <= 1'b0;
        end else begin
            r_have_held <= n_have_held;
        end
    end

endmodule

// ----- sv/rlcm_queue.sv -----
// ----------------------------------------------------------------------------
// rlcm_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module rlcm_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);

    logic [DW-1:0] r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          n_wr;
    logic          n_rd;
    logic [1:0]    n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = !r_wr;
        end
        if (i_pop) begin
            n_rd = !r_rd;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- sv/rlcm_back.sv -----
// ----------------------------------------------------------------------------
// rlcm_back
// Execution side: phase sequencing, channel-serial interpolation with one
// shared multiplier, mean by reciprocal multiply, output register.
// ----------------------------------------------------------------------------
module rlcm_back #(
    parameter int MAXC = 8,
    parameter int SB   = 24,
    parameter int F    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    output logic                           o_cmd_pop,
    input  rlcm_pkg::t_cmd_ctl             i_cmd_ctl,
    input  logic [MAXC*SB-1:0]             i_cmd_samples,
    input  rlcm_pkg::t_chmap               i_map,
    input  logic [F+4:0]                   i_step,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [rlcm_pkg::NUM_CH*SB-1:0] o_data,
    output logic                           o_last
);

    localparam int PW   = F + 5;
    localparam int PRW  = SB + F + 2;
    localparam int NW   = SB + 3;
    localparam int K    = NW + 3;
    localparam int MW   = K + 1;
    localparam int CW   = $clog2(MAXC + 1);
    localparam int CIW  = (MAXC > 1) ? $clog2(MAXC) : 1;
    localparam int NCH  = rlcm_pkg::NUM_CH;
    localparam int CCW  = rlcm_pkg::CH_CFG_W;

    localparam logic [PW-1:0]         PH_ONE = PW'(1) << F;
    localparam logic [PW-1:0]         PH_TWO = PW'(1) << (F + 1);
    localparam logic signed [PRW-1:0] HALF   = PRW'(1) << (F - 1);

    localparam logic [MW-1:0] RCP1 = MW'((64'd1 << K) / 64'd1);
    localparam logic [MW-1:0] RCP2 = MW'(((64'd1 << K) + 64'd1) / 64'd2);
    localparam logic [MW-1:0] RCP3 = MW'(((64'd1 << K) + 64'd2) / 64'd3);
    localparam logic [MW-1:0] RCP4 = MW'(((64'd1 << K) + 64'd3) / 64'd4);
    localparam logic [MW-1:0] RCP5 = MW'(((64'd1 << K) + 64'd4) / 64'd5);
    localparam logic [MW-1:0] RCP6 = MW'(((64'd1 << K) + 64'd5) / 64'd6);
    localparam logic [MW-1:0] RCP7 = MW'(((64'd1 << K) + 64'd6) / 64'd7);
    localparam logic [MW-1:0] RCP8 = MW'(((64'd1 << K) + 64'd7) / 64'd8);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_CALC  = 7'b0000100,
        S_ABS   = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_QUOT  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state                 r_state, n_state;
    rlcm_pkg::t_kind        r_kind, n_kind;
    logic                   r_two, n_two;
    logic [PW-1:0]          r_phase, n_phase;
    logic                   r_sel_held, n_sel_held;
    logic [CW-1:0]          r_iss, n_iss;
    logic                   r_pv, n_pv;
    logic                   r_ov, n_ov;

    logic signed [SB-1:0]   r_held [MAXC];
    logic signed [SB-1:0]   n_held [MAXC];
    logic signed [SB-1:0]   r_new  [MAXC];
    logic signed [SB-1:0]   n_new  [MAXC];
    logic signed [SB-1:0]   r_lane [MAXC];
    logic signed [SB-1:0]   n_lane [MAXC];
    logic signed [SB-1:0]   r_od   [NCH];
    logic signed [SB-1:0]   n_od   [NCH];
    logic                   r_olast, n_olast;
    logic [CIW-1:0]         r_pidx, n_pidx;
    logic signed [PRW-1:0]  r_prod, n_prod;
    logic signed [SB-1:0]   r_pa, n_pa;
    logic signed [NW-1:0]   r_acc, n_acc;
    logic                   r_neg, n_neg;
    logic [NW-1:0]          r_mag, n_mag;
    logic [NW+MW-1:0]       r_dprod, n_dprod;

    logic [PW-1:0]          w_phase_next;
    logic [PW-1:0]          w_lim;
    logic                   w_cont;
    logic                   w_out_free;
    logic [CW-1:0]          w_nlanes;
    logic [CIW-1:0]         w_idx;
    logic signed [SB-1:0]   w_a;
    logic signed [SB-1:0]   w_b;
    logic signed [SB:0]     w_diff;
    logic signed [F:0]      w_frac;
    logic signed [PRW-1:0]  w_rnd;
    logic signed [PRW-1:0]  w_shf;
    logic signed [SB+1:0]   w_lsum;
    logic signed [SB-1:0]   w_lerp;
    logic [MW-1:0]          w_rcp;
    logic [NW-1:0]          w_q;
    logic [NW-1:0]          w_s;
    logic signed [SB-1:0]   w_lane_ext [NCH];

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign o_valid   = r_ov;
    assign o_last    = r_olast;

    always_comb begin
        for (int j = 0; j < NCH; j++) begin
            o_data[j*SB +: SB] = r_od[j];
        end
    end

    always_comb begin
        unique case (i_map.mode)
            rlcm_pkg::MODE_EQ:     w_nlanes = CW'(i_map.out_ch);
            rlcm_pkg::MODE_MEAN:   w_nlanes = CW'(i_map.in_ch);
            rlcm_pkg::MODE_REPEAT: w_nlanes = CW'(1);
            default:               w_nlanes = CW'(1);
        endcase
        unique case (i_map.in_ch)
            4'd2:    w_rcp = RCP2;
            4'd3:    w_rcp = RCP3;
            4'd4:    w_rcp = RCP4;
            4'd5:    w_rcp = RCP5;
            4'd6:    w_rcp = RCP6;
            4'd7:    w_rcp = RCP7;
            4'd8:    w_rcp = RCP8;
            default: w_rcp = RCP1;
        endcase
    end

    always_comb begin
        w_phase_next = r_phase + i_step;
        w_lim        = r_two ? PH_TWO : PH_ONE;
        w_cont       = (r_kind == rlcm_pkg::KIND_FLUSH) ? (w_phase_next < w_lim)
                                                        : (w_phase_next < PH_ONE);
        w_out_free   = !r_ov || i_ready;

        // interpolation: a + floor(((b - a) * frac + ONE/2) / ONE)
        w_idx  = r_iss[CIW-1:0];
        w_b    = r_new[w_idx];
        w_a    = r_sel_held ? r_held[w_idx] : r_new[w_idx];
        w_diff = {w_b[SB-1], w_b} - {w_a[SB-1], w_a};
        w_frac = {1'b0, r_phase[F-1:0]};
        w_rnd  = r_prod + HALF;
        w_shf  = w_rnd >>> F;
        w_lsum = w_shf[SB+1:0] + {{2{r_pa[SB-1]}}, r_pa};
        w_lerp = w_lsum[SB-1:0];

        w_q = r_dprod[K +: NW];
        w_s = r_neg ? -w_q : w_q;

        for (int j = 0; j < NCH; j++) begin
            w_lane_ext[j] = '0;
        end
        for (int j = 0; j < MAXC; j++) begin
            w_lane_ext[j] = r_lane[j];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_two      = r_two;
        n_phase    = r_phase;
        n_sel_held = r_sel_held;
        n_iss      = r_iss;
        n_pv       = r_pv;
        n_ov       = r_ov;
        n_held     = r_held;
        n_new      = r_new;
        n_lane     = r_lane;
        n_od       = r_od;
        n_olast    = r_olast;
        n_pidx     = r_pidx;
        n_prod     = r_prod;
        n_pa       = r_pa;
        n_acc      = r_acc;
        n_neg      = r_neg;
        n_mag      = r_mag;
        n_dprod    = r_dprod;

        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    for (int c = 0; c < MAXC; c++) begin
                        n_new[c] = i_cmd_samples[c*SB +: SB];
                    end
                    n_kind  = i_cmd_ctl.kind;
                    n_two   = i_cmd_ctl.two_frames;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_iss = '0;
                n_acc = '0;
                n_pv  = 1'b0;
                unique case (r_kind)
                    rlcm_pkg::KIND_LOAD: begin
                        n_held  = r_new;
                        n_state = S_IDLE;
                    end
                    rlcm_pkg::KIND_RUN: begin
                        if (r_phase < PH_ONE) begin
                            n_sel_held = 1'b1;
                            n_state    = S_CALC;
                        end else begin
                            n_phase = r_phase - PH_ONE;
                            n_held  = r_new;
                            n_state = S_IDLE;
                        end
                    end
                    rlcm_pkg::KIND_FLUSH: begin
                        if (r_phase < w_lim) begin
                            n_sel_held = r_two && (r_phase < PH_ONE);
                            n_state    = S_CALC;
                        end else begin
                            n_phase = '0;
                            n_state = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_CALC: begin
                if (r_iss != w_nlanes) begin
                    n_prod = w_diff * w_frac;
                    n_pa   = w_a;
                    n_pidx = w_idx;
                    n_pv   = 1'b1;
                    n_iss  = r_iss + 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    unique case (i_map.mode)
                        rlcm_pkg::MODE_EQ: begin
                            n_lane[r_pidx] = w_lerp;
                        end
                        rlcm_pkg::MODE_MEAN: begin
                            n_acc = r_acc + {{3{w_lerp[SB-1]}}, w_lerp};
                        end
                        default: begin
                            for (int c = 0; c < MAXC; c++) begin
                                n_lane[c] = w_lerp;
                            end
                        end
                    endcase
                end
                if (r_iss == w_nlanes) begin
                    n_state = (i_map.mode == rlcm_pkg::MODE_MEAN) ? S_ABS : S_EMIT;
                end
            end
            S_ABS: begin
                n_neg   = r_acc[NW-1];
                n_mag   = r_acc[NW-1] ? -r_acc : r_acc;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_dprod = r_mag * w_rcp;
                n_state = S_QUOT;
            end
            S_QUOT: begin
                for (int c = 0; c < MAXC; c++) begin
                    n_lane[c] = w_s[SB-1:0];
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    for (int j = 0; j < NCH; j++) begin
                        n_od[j] = (CCW'(j) < i_map.out_ch) ? w_lane_ext[j] : '0;
                    end
                    n_ov    = 1'b1;
                    n_olast = !w_cont;
                    n_phase = w_phase_next;
                    n_state = S_START;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_two      <= n_two;
        r_sel_held <= n_sel_held;
        r_iss      <= n_iss;
        r_held     <= n_held;
        r_new      <= n_new;
        r_lane     <= n_lane;
        r_od       <= n_od;
        r_olast    <= n_olast;
        r_pidx     <= n_pidx;
        r_prod     <= n_prod;
        r_pa       <= n_pa;
        r_acc      <= n_acc;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_dprod    <= n_dprod;
    end

endmodule

// ----- sv/linear_resampler_channel_mapper.sv -----
// ----------------------------------------------------------------------------
// linear_resampler_channel_mapper
// Linear interpolation sample rate converter with channel mapping.
// ----------------------------------------------------------------------------
// Frames enter through a two-deep command queue, so up to two frames are
// taken while the back end is busy. A frame that yields no output (the
// first of a stream, or one skipped when decimating) only passes through
// the start state of the back end. For each output frame the channels go
// one per cycle through the single interpolation multiplier: the output
// channels with equal counts, input channel zero alone when it is repeated,
// and every input channel, then the abs, multiply and quotient states, when
// channels are averaged. The emit state holds while the output register
// waits on i_m_axis_tready. No clearing pass after reset.
// ----------------------------------------------------------------------------
module linear_resampler_channel_mapper #(
    parameter int MAX_CHANNELS    = 8,
    parameter int SAMPLE_BITS     = 24,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // in_ch0 .. in_ch7, SAMPLE_BITS each, from the lowest bit up
    input  logic [rlcm_pkg::NUM_CH*SAMPLE_BITS-1:0]  i_s_axis_tdata,
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  logic                                     i_s_axis_tlast,   // flush
    // out_ch0 .. out_ch7, SAMPLE_BITS each, from the lowest bit up
    output logic [rlcm_pkg::NUM_CH*SAMPLE_BITS-1:0]  o_m_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    output logic                                     o_m_axis_tlast,   // last_of_run
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [rlcm_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [rlcm_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    localparam int SB   = SAMPLE_BITS;
    localparam int F    = PHASE_FRAC_BITS;
    localparam int PW   = F + 5;
    localparam int CCW  = rlcm_pkg::CH_CFG_W;
    localparam int STW  = rlcm_pkg::STEP_W;
    localparam int SW   = ((STW > PW) ? STW : PW) + 1;
    localparam int CTLW = $bits(rlcm_pkg::t_cmd_ctl);
    localparam int DW   = CTLW + MAX_CHANNELS * SB;

    localparam logic [SW-1:0]  STEP_LO = SW'(1) << (F - 5);
    localparam logic [SW-1:0]  STEP_HI = SW'(1) << (F + 4);
    localparam logic [CCW-1:0] CH_MAX  = CCW'(MAX_CHANNELS);

    logic [CCW-1:0]             r_in_ch;
    logic [CCW-1:0]             r_out_ch;
    logic [STW-1:0]             r_step;

    logic [CCW-1:0]             w_ic;
    logic [CCW-1:0]             w_oc;
    logic [SW-1:0]              w_step_ext;
    logic [SW-1:0]              w_step_clamp;
    logic [PW-1:0]              w_step;
    rlcm_pkg::t_chmap           w_map;

    logic                       w_q_full;
    logic                       w_push;
    rlcm_pkg::t_cmd_ctl         w_push_ctl;
    logic [MAX_CHANNELS*SB-1:0] w_push_smp;
    logic                       w_pop;
    logic                       w_q_valid;
    logic [DW-1:0]              w_q_data;
    rlcm_pkg::t_cmd_ctl         w_pop_ctl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ch  <= CCW'(2);
            r_out_ch <= CCW'(2);
            r_step   <= STW'(65536);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rlcm_pkg::REG_IN_CH:  r_in_ch  <= i_cfg_data[CCW-1:0];
                rlcm_pkg::REG_OUT_CH: r_out_ch <= i_cfg_data[CCW-1:0];
                rlcm_pkg::REG_STEP:   r_step   <= i_cfg_data[STW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_in_ch == '0) begin
            w_ic = CCW'(1);
        end else if (r_in_ch > CH_MAX) begin
            w_ic = CH_MAX;
        end else begin
            w_ic = r_in_ch;
        end
        priority if (r_out_ch == '0) begin
            w_oc = CCW'(1);
        end else if (r_out_ch > CH_MAX) begin
            w_oc = CH_MAX;
        end else begin
            w_oc = r_out_ch;
        end

        w_map.in_ch  = w_ic;
        w_map.out_ch = w_oc;
        priority if (w_ic == w_oc) begin
            w_map.mode = rlcm_pkg::MODE_EQ;
        end else if (w_ic > w_oc) begin
            w_map.mode = rlcm_pkg::MODE_MEAN;
        end else begin
            w_map.mode = rlcm_pkg::MODE_REPEAT;
        end

        w_step_ext = SW'(r_step);
        priority if (w_step_ext < STEP_LO) begin
            w_step_clamp = STEP_LO;
        end else if (w_step_ext > STEP_HI) begin
            w_step_clamp = STEP_HI;
        end else begin
            w_step_clamp = w_step_ext;
        end
        w_step = w_step_clamp[PW-1:0];
    end

    rlcm_front #(
        .MAXC (MAX_CHANNELS),
        .SB   (SB)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_q_full  (w_q_full),
        .o_push    (w_push),
        .o_ctl     (w_push_ctl),
        .o_samples (w_push_smp)
    );

    rlcm_queue #(
        .DW (DW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_ctl, w_push_smp}),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_pop_ctl = rlcm_pkg::t_cmd_ctl'(w_q_data[DW-1 -: CTLW]);

    rlcm_back #(
        .MAXC (MAX_CHANNELS),
        .SB   (SB),
        .F    (F)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_q_valid),
        .o_cmd_pop     (w_pop),
        .i_cmd_ctl     (w_pop_ctl),
        .i_cmd_samples (w_q_data[MAX_CHANNELS*SB-1:0]),
        .i_map         (w_map),
        .i_step        (w_step),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_data        (o_m_axis_tdata),
        .o_last        (o_m_axis_tlast)
    );

endmodule

// ----- bench/linear_resampler_channel_mapper_tb.sv -----
// ----------------------------------------------------------------------------
// linear_resampler_channel_mapper_tb
// Self-checking bench for the linear resampler with channel mapping. Audio
// frames are streamed in under random back-pressure on both sides. An
// in-bench resampler tracks the held frame, the phase and the channel map,
// and every output frame is compared channel by channel with its
// prediction. Register settings change between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module linear_resampler_channel_mapper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlcm_pkg::*;

    localparam int      CLK_PERIOD   = 12;
    localparam int      RESET_CYCLES = 6;
    localparam int      SW           = 24;
    localparam longint  ONE          = 65536;   // Q16.16 unity phase
    localparam int      MAX_RUN      = 64;
    localparam int      IDLE_PCT     = 27;
    localparam int      HOLD_CYCLES  = 400;
    localparam int      STALL_LIMIT  = 3000;
    localparam int      DRAIN_CYCLES = 40;
    localparam int      PHASE_ITEMS  = 23;
    localparam int      RAND_PHASES  = 10;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;   // not mapped

    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef logic [NUM_CH-1:0][SW-1:0] t_chans;
    typedef struct packed {
        logic   flush;
        t_chans ch;
    } t_in_frame;
    typedef struct packed {
        logic   last;
        t_chans ch;
    } t_out_frame;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [NUM_CH*SW-1:0]   in_tdata = '0;
    logic                   in_tvalid = 1'b0;
    logic                   in_tready;
    logic                   in_tlast = 1'b0;
    logic [NUM_CH*SW-1:0]   out_tdata;
    logic                   out_tvalid;
    logic                   out_tready = 1'b0;
    logic                   out_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // resampler state and register copies
    logic [CH_CFG_W-1:0]    reg_in_ch = 4'd2;
    logic [CH_CFG_W-1:0]    reg_out_ch = 4'd2;
    logic [STEP_W-1:0]      reg_step = 21'd65536;
    t_chans                 held_q = '0;
    longint                 phase_q = 0;
    bit                     held_valid = 1'b0;

    t_in_frame              pending_q[$];
    t_out_frame             expected_q[$];
    int                     pushed_cnt = 0;
    int                     taken_cnt = 0;
    int                     err_cnt = 0;
    int                     stall_cycles = 0;
    bit                     in_sent = 1'b0;
    bit                     no_idle = 1'b0;
    bit                     rx_hold_req = 1'b0;
    int                     rx_hold_left = 0;

    linear_resampler_channel_mapper uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (in_tdata),
        .i_s_axis_tvalid (in_tvalid),
        .o_s_axis_tready (in_tready),
        .i_s_axis_tlast  (in_tlast),
        .o_m_axis_tdata  (out_tdata),
        .o_m_axis_tvalid (out_tvalid),
        .i_m_axis_tready (out_tready),
        .o_m_axis_tlast  (out_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial forever #(CLK_PERIOD/2) i_clk = ~i_clk;

    function automatic int eff_count(logic [CH_CFG_W-1:0] c);
        if (c == 0) return 1;
        if (c > NUM_CH) return NUM_CH;
        return c;
    endfunction

    function automatic longint eff_step(logic [STEP_W-1:0] s);
        if (s < ONE / 32) return ONE / 32;
        if (s > ONE * 16) return ONE * 16;
        return s;
    endfunction

    function automatic longint interp(logic [SW-1:0] a, logic [SW-1:0] b, logic [15:0] frac);
        longint sa, sb, f, v;
        sa = $signed(a);
        sb = $signed(b);
        f  = frac;
        v  = sa * (ONE - f) + sb * f + ONE / 2;
        return v >>> 16;
    endfunction

    function automatic t_out_frame mix_frame(t_chans fa, t_chans fb, logic [15:0] frac);
        t_out_frame r;
        int         ic, oc;
        longint     s, sum;
        ic = eff_count(reg_in_ch);
        oc = eff_count(reg_out_ch);
        r  = '0;
        for (int j = 0; j < oc; j++) begin
            if (ic == oc) begin
                s = interp(fa[j], fb[j], frac);
            end else if (ic > oc) begin
                sum = 0;
                for (int c = 0; c < ic; c++) sum += interp(fa[c], fb[c], frac);
                s = sum / ic;
            end else begin
                s = interp(fa[0], fb[0], frac);
            end
            r.ch[j] = s[SW-1:0];
        end
        return r;
    endfunction

    task automatic resample_frame(t_in_frame f);
        t_out_frame run_q[$];
        t_out_frame r;
        longint     step, frames;
        step = eff_step(reg_step);
        if (f.flush) begin
            frames = held_valid ? 2 : 1;
            while (phase_q < frames * ONE && run_q.size() < MAX_RUN) begin
                if (frames == 2 && (phase_q >> 16) == 0)
                    run_q = {run_q, mix_frame(held_q, f.ch, phase_q[15:0])};
                else
                    run_q = {run_q, mix_frame(f.ch, f.ch, phase_q[15:0])};
                phase_q += step;
            end
            held_q     = '0;
            phase_q    = 0;
            held_valid = 1'b0;
        end else if (!held_valid) begin
            held_q     = f.ch;
            held_valid = 1'b1;
        end else begin
            while (phase_q < ONE && run_q.size() < MAX_RUN) begin
                run_q = {run_q, mix_frame(held_q, f.ch, phase_q[15:0])};
                phase_q += step;
            end
            if (phase_q >= ONE) phase_q -= ONE;
            held_q = f.ch;
        end
        if (run_q.size() > 0) begin
            r = run_q[run_q.size() - 1];
            r.last = 1'b1;
            run_q[run_q.size() - 1] = r;
        end
        expected_q = {expected_q, run_q};
    endtask

    // input side: prediction at acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && in_tvalid && in_tready) begin
            resample_frame({in_tlast, in_tdata});
            taken_cnt++;
            in_sent = 1'b1;
        end
    end

    always @(negedge i_clk) begin : frame_driver
        t_in_frame nxt;
        if (i_rst_n && (!in_tvalid || in_sent)) begin
            in_sent = 1'b0;
            if (pending_q.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = pending_q[0];
                pending_q.delete(0);
                in_tvalid <= 1'b1;
                in_tdata  <= nxt.ch;
                in_tlast  <= nxt.flush;
            end else begin
                in_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_tready <= 1'b0;
        end else begin
            out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_frame got, want;
        if (i_rst_n && out_tvalid && out_tready) begin
            got.ch   = out_tdata;
            got.last = out_tlast;
            if (expected_q.size() == 0) begin
                $error("unexpected output transaction");
                err_cnt++;
            end else begin
                want = expected_q[0];
                expected_q.delete(0);
                for (int j = 0; j < NUM_CH; j++) begin
                    if (got.ch[j] !== want.ch[j]) begin
                        $error("out_ch%0d: expected %0d, actual %0d",
                               j, $signed(want.ch[j]), $signed(got.ch[j]));
                        err_cnt++;
                    end
                end
                if (got.last !== want.last) begin
                    $error("last_of_run: expected %0b, actual %0b", want.last, got.last);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            REG_IN_CH:  reg_in_ch  = val[CH_CFG_W-1:0];
            REG_OUT_CH: reg_out_ch = val[CH_CFG_W-1:0];
            REG_STEP:   reg_step   = val[STEP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // upper data bits of the channel registers carry junk
    task automatic set_config(logic [CH_CFG_W-1:0] ich, logic [CH_CFG_W-1:0] och,
                              logic [STEP_W-1:0] step);
        logic [CFG_DATA_W-CH_CFG_W-1:0] junk;
        junk = (CFG_DATA_W-CH_CFG_W)'($urandom());
        write_reg(REG_IN_CH, {junk, ich});
        junk = (CFG_DATA_W-CH_CFG_W)'($urandom());
        write_reg(REG_OUT_CH, {junk, och});
        write_reg(REG_STEP, step);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (taken_cnt != pushed_cnt || expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return SW'($urandom_range(15) - 8);
            default: return SW'($urandom());
        endcase
    endfunction

    function automatic t_in_frame rand_frame(bit flush);
        t_in_frame f;
        f.flush = flush;
        for (int j = 0; j < NUM_CH; j++) f.ch[j] = pick_sample();
        return f;
    endfunction

    function automatic t_in_frame const_frame(logic [SW-1:0] v, bit flush);
        t_in_frame f;
        f.flush = flush;
        for (int j = 0; j < NUM_CH; j++) f.ch[j] = v;
        return f;
    endfunction

    function automatic logic [CH_CFG_W-1:0] pick_count();
        case ($urandom_range(7))
            0:       return CH_CFG_W'(0);
            1:       return CH_CFG_W'($urandom_range(15, 9));
            2:       return CH_CFG_W'(1);
            3:       return CH_CFG_W'(8);
            default: return CH_CFG_W'($urandom_range(8, 1));
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(9))
            0:       return STEP_W'($urandom_range(2047));
            1:       return STEP_W'($urandom_range(21'h1FFFFF, 1048577));
            2:       return STEP_W'(2048);
            3:       return STEP_W'(1048576);
            4, 5:    return STEP_W'($urandom_range(65535, 2048));
            6, 7:    return STEP_W'($urandom_range(131072, 65536));
            default: return STEP_W'($urandom_range(1048576, 131073));
        endcase
    endfunction

    task automatic offer(t_in_frame f);
        pending_q = {pending_q, f};
        pushed_cnt++;
    endtask

    // streams of a first frame, runs and a flush, now and then broken
    task automatic offer_stream(int n);
        for (int i = 0; i < n; i++) offer(rand_frame($urandom_range(5) == 0));
    endtask

    initial begin : stimulus
        int p;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: lone flush, then a full stream
        offer(rand_frame(1'b1));
        offer(const_frame(S_MAX, 1'b0));
        offer(const_frame(S_MIN, 1'b0));
        offer(rand_frame(1'b0));
        offer(rand_frame(1'b1));
        wait_drained();

        // channel averaging, step below range (longest runs)
        write_reg(REG_SPARE, 21'h1FFFFF);
        set_config(4'd8, 4'd3, 21'd0);
        @(posedge i_clk);
        offer(const_frame(S_MAX, 1'b0));
        offer(const_frame(S_MIN, 1'b0));
        offer(const_frame(S_MAX, 1'b1));
        wait_drained();

        // zero and oversized counts, step above range
        set_config(4'd0, 4'd15, 21'h1FFFFF);
        @(posedge i_clk);
        repeat (4) offer(rand_frame(1'b0));
        offer(rand_frame(1'b1));
        wait_drained();

        set_config(4'd9, 4'd8, 21'd1048576);
        @(posedge i_clk);
        repeat (3) offer(rand_frame(1'b0));
        offer(rand_frame(1'b1));
        wait_drained();

        set_config(4'd1, 4'd1, 21'd2048);
        @(posedge i_clk);
        offer(const_frame(S_MIN, 1'b0));
        offer(const_frame(S_MAX, 1'b0));
        offer(rand_frame(1'b1));
        wait_drained();

        for (p = 0; p < RAND_PHASES; p++) begin
            if (p == 2)
                set_config(4'd2, 4'd2, 21'd32768);
            else
                set_config(pick_count(), pick_count(), pick_step());
            @(posedge i_clk);
            if (p == 2) rx_hold_req = 1'b1;
            no_idle = (p == 4);
            if (p == 6) begin
                offer_stream(PHASE_ITEMS / 2);
                wait_drained();
                @(posedge i_clk);
                offer_stream(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                offer_stream(PHASE_ITEMS);
            end
            wait_drained();
        end

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
